FILE: hw/rtl/sfq_pkg.sv
// Shared types, codes and key helper functions of the searchable FIFO queue.
`default_nettype none

package sfq_pkg;

  localparam int SFQ_DEPTH     = 16;
  localparam int SFQ_KEY_CHARS = 4;

  // Operation codes carried in tuser of the input channel.
  localparam logic [2:0] FN_PUSH    = 3'd0;
  localparam logic [2:0] FN_POP     = 3'd1;
  localparam logic [2:0] FN_FIND    = 3'd2;
  localparam logic [2:0] FN_REPLACE = 3'd3;
  localparam logic [2:0] FN_LIST    = 3'd4;

  // Result status codes.
  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_EMPTY     = 2'd1;
  localparam logic [1:0] RES_NOT_FOUND = 2'd2;
  localparam logic [1:0] RES_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_CMP,
    S_FLUSH
  } sfq_state_e;

  typedef enum logic [2:0] {
    EM_ZERO,
    EM_PUSH_OK,
    EM_FULL,
    EM_EMPTY,
    EM_NOT_FOUND,
    EM_POP,
    EM_FOUND,
    EM_PEND
  } sfq_emit_e;

  typedef struct packed {
    logic      load_op;
    logic      ram_rd;
    logic      scan_clr;
    logic      scan_inc;
    logic      push_do;
    logic      pop_do;
    logic      repl_wr;
    logic      pend_set;
    logic      pend_clr;
    logic      emit;
    sfq_emit_e kind;
    logic      emit_last;
  } sfq_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       empty;
    logic       full;
    logic       last_scan;
    logic       hit;
    logic       pmatch;
    logic       pend_valid;
    logic       out_free;
  } sfq_stat_t;

  function automatic logic [7:0] key_byte(logic [31:0] k, int i);
    return k[8*(i%4) +: 8];
  endfunction

  // Keep at most kch characters and clear everything after the first zero byte.
  function automatic logic [31:0] norm_key(logic [31:0] k, int kch);
    logic [31:0] r;
    logic        stop;
    r    = '0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (i >= kch || k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [2:0] key_length(logic [31:0] k);
    logic [2:0] n;
    logic       stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (k[8*i +: 8] == 8'd0) stop = 1'b1;
      if (!stop) n = n + 3'd1;
    end
    return n;
  endfunction

  // Substring test of a pattern of plen characters within an entry.
  function automatic logic contains(logic [31:0] e, logic [31:0] p, logic [2:0] plen);
    logic [2:0] elen;
    logic       hit;
    logic       ok;
    elen = key_length(e);
    hit  = (plen == 3'd0);
    for (int o = 0; o < 4; o++) begin
      ok = (plen != 3'd0) && ((o + int'(plen)) <= int'(elen));
      for (int j = 0; j < 4; j++) begin
        if (j < int'(plen) && key_byte(e, o + j) != key_byte(p, j)) ok = 1'b0;
      end
      hit = hit | ok;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sfq_ctrl.sv
// Operation sequencer of the searchable FIFO queue.
`default_nettype none

module sfq_ctrl import sfq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sfq_stat_t stat_i,
  output sfq_cmd_t       cmd_o
);

  sfq_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = EM_ZERO;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.func)
          FN_PUSH: begin
            if (stat_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.kind = EM_FULL;
              end else begin
                cmd_o.kind    = EM_PUSH_OK;
                cmd_o.push_do = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          FN_POP, FN_FIND, FN_REPLACE, FN_LIST: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                cmd_o.kind      = EM_EMPTY;
                state_d         = S_IDLE;
              end
            end else begin
              cmd_o.scan_clr = 1'b1;
              cmd_o.pend_clr = 1'b1;
              state_d        = S_READ;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              cmd_o.kind      = EM_ZERO;
              state_d         = S_IDLE;
            end
          end
        endcase
      end
      S_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        case (stat_i.func)
          FN_POP: begin
            if (stat_i.out_free) begin
              cmd_o.pop_do    = 1'b1;
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              cmd_o.kind      = EM_POP;
              state_d         = S_IDLE;
            end
          end
          FN_LIST: begin
            // Hold the newest match back until we know whether another follows.
            if (!(stat_i.pmatch && stat_i.pend_valid && !stat_i.out_free)) begin
              if (stat_i.pmatch) begin
                cmd_o.pend_set = 1'b1;
                if (stat_i.pend_valid) begin
                  cmd_o.emit = 1'b1;
                  cmd_o.kind = EM_PEND;
                end
              end
              if (stat_i.last_scan) begin
                state_d = S_FLUSH;
              end else begin
                cmd_o.scan_inc = 1'b1;
                state_d        = S_READ;
              end
            end
          end
          default: begin
            // Find and replace.
            if (stat_i.hit) begin
              if (stat_i.out_free) begin
                cmd_o.repl_wr   = (stat_i.func == FN_REPLACE);
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                cmd_o.kind      = EM_FOUND;
                state_d         = S_IDLE;
              end
            end else if (stat_i.last_scan) begin
              if (stat_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                cmd_o.kind      = EM_NOT_FOUND;
                state_d         = S_IDLE;
              end
            end else begin
              cmd_o.scan_inc = 1'b1;
              state_d        = S_READ;
            end
          end
        endcase
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.kind      = stat_i.pend_valid ? EM_PEND : EM_NOT_FOUND;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfq_dp.sv
// Datapath of the searchable FIFO queue: pointers, key store, compare and result register.
`default_nettype none

module sfq_dp import sfq_pkg::*; #(
  parameter int DEPTH     = SFQ_DEPTH,
  parameter int KEY_CHARS = SFQ_KEY_CHARS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [2:0]  func_i,
  input  wire logic [31:0] key_i,
  input  wire logic [2:0]  key_len_i,
  input  wire logic [31:0] new_value_i,
  input  wire sfq_cmd_t    cmd_i,
  output sfq_stat_t        stat_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic [31:0]      value_o,
  output logic [4:0]       position_o,
  output logic [4:0]       occupancy_o,
  output logic             last_o
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int KCH = (KEY_CHARS > 4) ? 4 : KEY_CHARS;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d, idx_q, idx_d;
  logic [CW-1:0] count_q, count_d;
  logic          pend_valid_q, pend_valid_d, out_valid_q, out_valid_d;

  logic [2:0]    func_q, plen_q;
  logic [31:0]   key_q, nv_q, pend_val_q;
  logic [4:0]    pend_pos_q;
  logic [1:0]    status_q;
  logic [31:0]   value_q;
  logic [4:0]    position_q, occupancy_q;
  logic          last_q;

  logic [31:0]   key_n, rdata;
  logic [2:0]    klen_n, plen_n;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot;
  logic [4:0]    scan_pos;
  logic          out_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;

  // Pattern length, saturated to the kept characters and to the pattern string.
  always_comb begin
    key_n  = norm_key(key_i, KCH);
    klen_n = key_length(key_n);
    plen_n = (key_len_i > 3'(KCH)) ? 3'(KCH) : key_len_i;
    if (plen_n > klen_n) plen_n = klen_n;
  end

  // Circular slot of the scan index.
  always_comb begin
    slot_sum = (AW+1)'(head_q) + (AW+1)'(idx_q);
    if (slot_sum >= (AW+1)'(DEPTH)) slot_sum = slot_sum - (AW+1)'(DEPTH);
    slot = slot_sum[AW-1:0];
  end

  assign scan_pos = 5'(CW'(idx_q) + CW'(1));
  assign out_free = !out_valid_q || out_ready_i;

  assign ram_we    = cmd_i.push_do || cmd_i.repl_wr;
  assign ram_waddr = cmd_i.push_do ? tail_q : slot;
  assign ram_wdata = cmd_i.push_do ? key_q : nv_q;

  sfq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (slot),
    .rdata_o (rdata)
  );

  always_comb begin
    stat_o.func       = func_q;
    stat_o.empty      = (count_q == '0);
    stat_o.full       = (count_q == CW'(DEPTH));
    stat_o.last_scan  = ((CW'(idx_q) + CW'(1)) == count_q);
    stat_o.hit        = (rdata == key_q);
    stat_o.pmatch     = contains(rdata, key_q, plen_q);
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
  end

  // Control state next values.
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q;
    if (cmd_i.push_do) begin
      tail_d  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.pop_do) begin
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.scan_clr) idx_d = '0;
    if (cmd_i.scan_inc) idx_d = idx_q + 1'b1;
    if (cmd_i.pend_clr) pend_valid_d = 1'b0;
    if (cmd_i.pend_set) pend_valid_d = 1'b1;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Operands, pending list match and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      func_q <= func_i;
      key_q  <= key_n;
      nv_q   <= norm_key(new_value_i, KCH);
      plen_q <= plen_n;
    end
    if (cmd_i.pend_set) begin
      pend_val_q <= rdata;
      pend_pos_q <= scan_pos;
    end
    if (cmd_i.emit) begin
      occupancy_q <= 5'(count_d);
      last_q      <= cmd_i.emit_last;
      status_q    <= RES_OK;
      value_q     <= '0;
      position_q  <= '0;
      case (cmd_i.kind)
        EM_PUSH_OK:   position_q <= 5'(count_d);
        EM_FULL:      status_q   <= RES_FULL;
        EM_EMPTY:     status_q   <= RES_EMPTY;
        EM_NOT_FOUND: status_q   <= RES_NOT_FOUND;
        EM_POP: begin
          value_q    <= rdata;
          position_q <= 5'd1;
        end
        EM_FOUND: begin
          value_q    <= (func_q == FN_REPLACE) ? nv_q : rdata;
          position_q <= scan_pos;
        end
        EM_PEND: begin
          value_q    <= pend_val_q;
          position_q <= pend_pos_q;
        end
        default: begin
          status_q <= RES_OK;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;
  assign position_o  = position_q;
  assign occupancy_o = occupancy_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/searchable_fifo_queue_unit.sv
// Top level of the searchable FIFO queue of short keys.
//
// Input channel s_axis: one transaction is one operation; tuser carries the
// operation code (push, pop, find, replace, pattern list), tdata the key,
// pattern length and replacement value. Output channel m_axis: each result is
// one transaction, tuser carries the status, tdata the value, 1-based position
// and occupancy, and tlast marks the final result of an operation.
// Sequence: an operation is taken in the idle state and decoded in the dispatch
// state. Push and the empty, full and unknown cases finish there. Pop reads
// the head entry; find and replace walk the queue from the head, visiting at
// most DEPTH entries through the key store's single registered read port, each
// entry in a read state and then a compare state. Pattern list visits every
// entry the same way and gives its final result from a flush state. Each match
// is held back until the next match or the end of the walk so that tlast lands
// on the final one.
// Reset clears the pointers and count and empties the output register; the
// key store holds no reset value and needs no clearing pass.
// A stalled receiver holds the output register; the walk stops at the next
// result until the register frees, and no result is dropped.
`default_nettype none

module searchable_fifo_queue_unit import sfq_pkg::*; #(
  parameter int DEPTH     = SFQ_DEPTH,
  parameter int KEY_CHARS = SFQ_KEY_CHARS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // key[31:0], key_len[34:32], new_value[66:35], zero
  input  wire logic [2:0]  s_axis_tuser,  // func[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // value[31:0], position[36:32], occupancy[41:37], zero
  output logic [1:0]       m_axis_tuser,  // status[1:0]
  output logic             m_axis_tlast
);

  sfq_cmd_t    cmd;
  sfq_stat_t   stat;
  logic [31:0] value;
  logic [4:0]  position;
  logic [4:0]  occupancy;

  sfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfq_dp #(
    .DEPTH     (DEPTH),
    .KEY_CHARS (KEY_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .func_i      (s_axis_tuser),
    .key_i       (s_axis_tdata[31:0]),
    .key_len_i   (s_axis_tdata[34:32]),
    .new_value_i (s_axis_tdata[66:35]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_o    (m_axis_tuser),
    .value_o     (value),
    .position_o  (position),
    .occupancy_o (occupancy),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, occupancy, position, value};

endmodule

`default_nettype wire
